// File: design/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared constants, codes and types of the ring peak decimator.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int RING_DEPTH  = 8192;
  localparam int MAX_COLUMNS = 2048;

  localparam int PTR_W    = $clog2(RING_DEPTH);
  localparam int CNT_W    = $clog2(RING_DEPTH + 1);
  localparam int AMP_W    = 8;
  localparam int SAMPLE_W = 9;
  localparam int COL_W    = 11;
  localparam int COLS_W   = 12;
  localparam int WIN_W    = 14;
  localparam int CMP_W    = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int DIV_W    = COL_W + 1 + CNT_W;
  localparam int DCNT_W   = $clog2(DIV_W);
  localparam int ADDR_W   = CNT_W + 1;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 14;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b1;

  localparam logic [WIN_W-1:0]  WINDOW_RESET  = WIN_W'(1000);
  localparam logic [COLS_W-1:0] COLUMNS_RESET = COLS_W'(512);

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int MARK_BIT = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD_FROM,
    ST_DIV_FROM,
    ST_LOAD_TO,
    ST_DIV_TO,
    ST_SAVE_TO,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } rpd_state_e;

  typedef struct packed {
    logic push;
    logic start;
    logic prep;
    logic load_from;
    logic load_to;
    logic div_step;
    logic save_to;
    logic walk_issue;
    logic load_out;
  } rpd_cmd_t;

  typedef struct packed {
    logic valid;
    logic div_last;
    logic walk_last;
    logic out_busy;
  } rpd_status_t;

  typedef struct packed {
    logic [AMP_W-1:0] last_amplitude;
    logic             enough_data;
    logic             restart_seen;
    logic [AMP_W-1:0] peak_amplitude;
  } rpd_result_t;

endpackage

// File: design/ring_peak_decimator.sv
// ----------------------------------------------------------------------------
// ring_peak_decimator
// Peak-detecting decimation over a ring of amplitude samples with markers.
// ----------------------------------------------------------------------------
// A push transaction (tuser 0) stores one sample. A query transaction
// (tuser 1) returns the peak amplitude and marker flag of one display
// column, with the enough_data flag and the newest amplitude: two 26-step
// shared divisions fix the column bounds, then the stored samples are read
// one per cycle through the single read port of the sample RAM. An invalid
// query skips the divisions and the walk. The input is not ready while a
// query runs; the result waits in an output register, and pushes are still
// taken while it waits. No clearing pass after reset is needed.
module ring_peak_decimator
  import rpd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // sample_value[8:0], column_index[19:9]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // operation[0]
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // peak_amplitude[7:0], restart_seen[8], enough_data[9], last_amplitude[17:10]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  rpd_cmd_t    cmd;
  rpd_status_t status;
  rpd_result_t result;

  rpd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_op_i   (s_axis_tuser_i),
    .in_ready_o(s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rpd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   (s_axis_tdata_i[SAMPLE_W-1:0]),
    .column_i   (s_axis_tdata_i[SAMPLE_W+COL_W-1:SAMPLE_W]),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .result_o   (result)
  );

  assign m_axis_tdata_o = OUT_DATA_W'(result);

endmodule

// File: design/rpd_ram.sv
// ----------------------------------------------------------------------------
// rpd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rpd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rpd_ctrl.sv
// ----------------------------------------------------------------------------
// rpd_ctrl
// Sequencer for pushes and column queries: divisions, store walk, result.
// ----------------------------------------------------------------------------
module rpd_ctrl
  import rpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_op_i,
  output logic        in_ready_o,
  input  rpd_status_t status_i,
  output rpd_cmd_t    cmd_o
);

  rpd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_op_i == OP_QUERY)) state_d = ST_PREP;
      end
      ST_PREP:      state_d = ST_LOAD_FROM;
      ST_LOAD_FROM: state_d = status_i.valid ? ST_DIV_FROM : ST_FINISH;
      ST_DIV_FROM: begin
        if (status_i.div_last) state_d = ST_LOAD_TO;
      end
      ST_LOAD_TO:   state_d = ST_DIV_TO;
      ST_DIV_TO: begin
        if (status_i.div_last) state_d = ST_SAVE_TO;
      end
      ST_SAVE_TO:   state_d = ST_WALK;
      ST_WALK: begin
        if (status_i.walk_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:     state_d = ST_FINISH;
      ST_FINISH: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.push  = in_valid_i && (in_op_i == OP_PUSH);
        cmd_o.start = in_valid_i && (in_op_i == OP_QUERY);
      end
      ST_PREP:      cmd_o.prep = 1'b1;
      ST_LOAD_FROM: cmd_o.load_from = 1'b1;
      ST_DIV_FROM:  cmd_o.div_step = 1'b1;
      ST_LOAD_TO:   cmd_o.load_to = 1'b1;
      ST_DIV_TO:    cmd_o.div_step = 1'b1;
      ST_SAVE_TO:   cmd_o.save_to = 1'b1;
      ST_WALK:      cmd_o.walk_issue = 1'b1;
      ST_DRAIN:     cmd_o = '0;
      ST_FINISH:    cmd_o.load_out = !status_i.out_busy;
      default:      cmd_o = '0;
    endcase
  end

endmodule

// File: design/rpd_datapath.sv
// ----------------------------------------------------------------------------
// rpd_datapath
// Sample ring, config registers, shared divider, column walk and result reg.
// ----------------------------------------------------------------------------
module rpd_datapath
  import rpd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic [COL_W-1:0]     column_i,
  input  rpd_cmd_t             cmd_i,
  output rpd_status_t          status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output rpd_result_t          result_o
);

  logic [WIN_W-1:0]  win_q;
  logic [COLS_W-1:0] colcfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= WINDOW_RESET;
      colcfg_q <= COLUMNS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW:  win_q <= cfg_wdata_i[WIN_W-1:0];
        CFG_COLUMNS: colcfg_q <= cfg_wdata_i[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // ring state
  logic [PTR_W-1:0] wp_q;
  logic [CNT_W-1:0] sw_q;
  logic [AMP_W-1:0] newest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      sw_q     <= '0;
      newest_q <= '0;
    end else if (cmd_i.push) begin
      wp_q     <= (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
      if (sw_q != CNT_W'(RING_DEPTH)) sw_q <= sw_q + CNT_W'(1);
      newest_q <= sample_i[AMP_W-1:0];
    end
  end

  // query setup
  logic [COL_W-1:0]  col_q;
  logic [COLS_W-1:0] cols_q, cols_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              valid_q, valid_d;
  logic [PTR_W-1:0]  start_q, start_d;
  logic [ADDR_W-1:0] start_sum;

  always_comb begin
    cols_d = (int'(colcfg_q) > MAX_COLUMNS) ? COLS_W'(MAX_COLUMNS) : colcfg_q;
    count_d = (CMP_W'(sw_q) < CMP_W'(win_q)) ? sw_q : CNT_W'(win_q);
    valid_d = (count_d >= CNT_W'(2)) && (cols_d != '0) && (COLS_W'(col_q) < cols_d);
    start_sum = ADDR_W'(wp_q) + ADDR_W'(RING_DEPTH) - ADDR_W'(count_d);
    start_d = (start_sum >= ADDR_W'(RING_DEPTH)) ?
              PTR_W'(start_sum - ADDR_W'(RING_DEPTH)) : PTR_W'(start_sum);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) col_q <= column_i;
    if (cmd_i.prep) begin
      cols_q  <= cols_d;
      count_q <= count_d;
      valid_q <= valid_d;
      start_q <= start_d;
    end
  end

  // restoring divider, one quotient bit per step
  logic [DIV_W-1:0]  num_q;
  logic [COLS_W:0]   rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [COLS_W:0]   rem_sh;
  logic              rem_ge;

  assign rem_sh = {rem_q[COLS_W-1:0], num_q[DIV_W-1]};
  assign rem_ge = rem_sh >= {1'b0, cols_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_from) begin
      num_q  <= DIV_W'(col_q) * DIV_W'(count_q);
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.load_to) begin
      num_q  <= (DIV_W'(col_q) + DIV_W'(1)) * DIV_W'(count_q);
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q  <= {num_q[DIV_W-2:0], rem_ge};
      rem_q  <= rem_ge ? rem_sh - {1'b0, cols_q} : rem_sh;
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
  end

  // column bounds and walk
  logic [CNT_W-1:0]  from_q, to_q, idx_q;
  logic [CNT_W-1:0]  quo, from_inc, to_lo;
  logic [ADDR_W-1:0] raddr_sum;
  logic [PTR_W-1:0]  raddr;
  logic              rd_vld_q;
  logic [SAMPLE_W-1:0] rdata;
  logic [AMP_W-1:0]  peak_q;
  logic              seen_q;

  assign quo      = num_q[CNT_W-1:0];
  assign from_inc = from_q + CNT_W'(1);
  assign to_lo    = (quo < from_inc) ? from_inc : quo;
  assign raddr_sum = ADDR_W'(start_q) + ADDR_W'(idx_q);
  assign raddr = (raddr_sum >= ADDR_W'(RING_DEPTH)) ?
                 PTR_W'(raddr_sum - ADDR_W'(RING_DEPTH)) : PTR_W'(raddr_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_to) from_q <= quo;
    if (cmd_i.save_to) begin
      to_q  <= (to_lo > count_q) ? count_q : to_lo;
      idx_q <= from_q;
    end else if (cmd_i.walk_issue) begin
      idx_q <= idx_q + CNT_W'(1);
    end
    if (cmd_i.prep) begin
      peak_q <= '0;
      seen_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (rdata[AMP_W-1:0] > peak_q) peak_q <= rdata[AMP_W-1:0];
      if (rdata[MARK_BIT]) seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.walk_issue;
    end
  end

  rpd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(wp_q),
    .wdata_i(sample_i),
    .re_i   (cmd_i.walk_issue),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // result register
  logic        out_vld_q;
  rpd_result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.peak_amplitude <= peak_q;
      out_q.restart_seen   <= seen_q;
      out_q.enough_data    <= valid_q;
      out_q.last_amplitude <= newest_q;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign result_o           = out_q;
  assign status_o.valid     = valid_q;
  assign status_o.div_last  = dcnt_q == DCNT_W'(DIV_W - 1);
  assign status_o.walk_last = (idx_q + CNT_W'(1)) == to_q;
  assign status_o.out_busy  = out_vld_q && !out_ready_i;

endmodule
